FILE: rtl/core/crcfc_pkg.sv
`timescale 1ns / 1ps

package crcfc_pkg;

    localparam int unsigned CHECK_BYTES = 4;
    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
    localparam logic [31:0] POLY_RESET  = 32'hEDB8_8320;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_end;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } t_out_word;

    // front -> queue write side
    typedef struct packed {
        logic      wr;
        logic      commit;
        logic      rewind;
        t_out_word data;
    } t_q_ctrl;

endpackage

FILE: rtl/core/crcfc_front.sv
`timescale 1ns / 1ps

module crcfc_front #(
    parameter int unsigned FRAME_DATA_BYTES = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  crcfc_pkg::t_in_word i_in_word,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_wdata,
    input  logic                i_q_full,
    output crcfc_pkg::t_q_ctrl  o_q_ctrl
);

    localparam int unsigned FRAME_LEN = FRAME_DATA_BYTES + crcfc_pkg::CHECK_BYTES;
    localparam int unsigned PW        = $clog2(FRAME_LEN + 1);

    logic [31:0]   r_poly;
    logic [31:0]   r_crc;
    logic [31:0]   n_crc;
    logic [PW-1:0] r_pos;
    logic [PW-1:0] n_pos;
    logic [7:0]    r_dly [crcfc_pkg::CHECK_BYTES];

    logic          accept;
    logic          fold;
    logic          frame_end;
    logic          crc_ok;
    logic [31:0]   crc_fold;
    logic [31:0]   check;

    function automatic logic [31:0] fold_byte(input logic [31:0] crc,
                                              input logic [7:0]  b,
                                              input logic [31:0] poly);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
        end
        return c;
    endfunction

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign fold       = r_pos >= PW'(crcfc_pkg::CHECK_BYTES);
    assign n_pos      = r_pos + PW'(1);
    assign frame_end  = (n_pos == PW'(FRAME_LEN)) || i_in_word.stream_end;
    assign crc_fold   = fold_byte(r_crc, r_dly[3], r_poly);
    assign n_crc      = fold ? crc_fold : r_crc;
    assign check      = {r_dly[2], r_dly[1], r_dly[0], i_in_word.in_byte};
    assign crc_ok     = (n_pos > PW'(crcfc_pkg::CHECK_BYTES)) && (check == n_crc);

    always_comb begin
        o_q_ctrl               = '0;
        o_q_ctrl.wr            = accept && fold;
        o_q_ctrl.commit        = accept && frame_end && crc_ok;
        o_q_ctrl.rewind        = accept && frame_end && !crc_ok;
        o_q_ctrl.data.out_byte = r_dly[3];
        o_q_ctrl.data.run_last = frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly <= crcfc_pkg::POLY_RESET;
            r_crc  <= crcfc_pkg::CRC_INIT;
            r_pos  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_poly <= i_cfg_wdata;
            end
            if (accept) begin
                if (frame_end) begin
                    r_crc <= crcfc_pkg::CRC_INIT;
                    r_pos <= '0;
                end else begin
                    r_crc <= n_crc;
                    r_pos <= n_pos;
                end
            end
        end
    end

    // last four bytes, [0] newest
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dly[0] <= i_in_word.in_byte;
            r_dly[1] <= r_dly[0];
            r_dly[2] <= r_dly[1];
            r_dly[3] <= r_dly[2];
        end
    end

endmodule

FILE: rtl/core/crcfc_queue.sv
`timescale 1ns / 1ps

module crcfc_queue #(
    parameter int unsigned FRAME_DATA_BYTES = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  crcfc_pkg::t_q_ctrl   i_q_ctrl,
    output logic                 o_full,
    output logic                 o_avail,
    input  logic                 i_rd_en,
    output crcfc_pkg::t_out_word o_rd_data
);

    localparam int unsigned AW    = $clog2(2 * FRAME_DATA_BYTES);
    localparam int unsigned DEPTH = 2 ** AW;

    crcfc_pkg::t_out_word r_mem [DEPTH];
    logic [AW:0] r_wr;
    logic [AW:0] r_cm;
    logic [AW:0] r_rd;
    logic [AW:0] n_wr;
    logic [AW:0] used;

    assign used    = r_wr - r_rd;
    assign o_full  = used == (AW + 1)'(DEPTH);
    assign o_avail = r_rd != r_cm;
    assign n_wr    = i_q_ctrl.wr ? r_wr + (AW + 1)'(1) : r_wr;

    // writes are speculative until the frame passes; a failed frame rewinds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_cm <= '0;
            r_rd <= '0;
        end else begin
            if (i_q_ctrl.rewind) begin
                r_wr <= r_cm;
            end else begin
                r_wr <= n_wr;
            end
            if (i_q_ctrl.commit) begin
                r_cm <= n_wr;
            end
            if (i_rd_en) begin
                r_rd <= r_rd + (AW + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_q_ctrl.wr) begin
            r_mem[r_wr[AW-1:0]] <= i_q_ctrl.data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[r_rd[AW-1:0]];
        end
    end

endmodule

FILE: rtl/core/crcfc_back.sv
`timescale 1ns / 1ps

module crcfc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_avail,
    output logic                 o_rd_en,
    input  crcfc_pkg::t_out_word i_rd_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output crcfc_pkg::t_out_word o_out_word
);

    logic r_m_vld;
    logic r_o_vld;
    logic o_free;
    logic m_move;

    assign o_free      = !r_o_vld || i_out_ready;
    assign m_move      = r_m_vld && o_free;
    assign o_rd_en     = i_avail && (!r_m_vld || m_move);
    assign o_out_valid = r_o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (o_rd_en) begin
                r_m_vld <= 1'b1;
            end else if (m_move) begin
                r_m_vld <= 1'b0;
            end
            if (m_move) begin
                r_o_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_move) begin
            o_out_word <= i_rd_data;
        end
    end

endmodule

FILE: rtl/core/crc32_frame_checker_core.sv
`timescale 1ns / 1ps
// Throughput: one input word per cycle unless the data queue (the only input
// stall) is full; one output word per cycle while i_out_ready is high and
// committed data waits, released once a frame's last check byte is accepted.
// Reset (synchronous, active low) clears the frame position, CRC, queue
// pointers and output valids; the polynomial returns to 0xEDB88320.
module crc32_frame_checker_core #(
    parameter int unsigned FRAME_DATA_BYTES = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  crcfc_pkg::t_in_word  i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output crcfc_pkg::t_out_word o_out_word,
    input  logic                 i_cfg_we,
    input  logic [31:0]          i_cfg_wdata
);

    crcfc_pkg::t_q_ctrl   q_ctrl;
    crcfc_pkg::t_out_word rd_data;
    logic                 q_full;
    logic                 q_avail;
    logic                 rd_en;

    crcfc_front #(
        .FRAME_DATA_BYTES(FRAME_DATA_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_full    (q_full),
        .o_q_ctrl    (q_ctrl)
    );

    crcfc_queue #(
        .FRAME_DATA_BYTES(FRAME_DATA_BYTES)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_ctrl  (q_ctrl),
        .o_full    (q_full),
        .o_avail   (q_avail),
        .i_rd_en   (rd_en),
        .o_rd_data (rd_data)
    );

    crcfc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_avail     (q_avail),
        .o_rd_en     (rd_en),
        .i_rd_data   (rd_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule
